// File: sv/nonuniform_dft_complex_to_real_2d_assert.svh
// assertion macros shared by the checker files of the nonuniform dft block
`ifndef NONUNIFORM_DFT_COMPLEX_TO_REAL_2D_ASSERT_SVH
`define NONUNIFORM_DFT_COMPLEX_TO_REAL_2D_ASSERT_SVH

// checked only outside reset
`define NDFT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define NDFT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: sv/ndft_pkg.sv
// shared types, constants and tables of the nonuniform dft block
package ndft_pkg;

   localparam int MAX_POINTS   = 4096;
   localparam int SLOT_BITS    = $clog2(MAX_POINTS);
   localparam int COUNT_BITS   = $clog2(MAX_POINTS) + 1;
   localparam int POS_BITS     = 32;
   localparam int SAMPLE_BITS  = 16;
   localparam int WAVE_BITS    = 32;
   localparam int VALUE_BITS   = 48;
   localparam int KPROD_BITS   = POS_BITS + WAVE_BITS;
   localparam int HALF_BITS    = KPROD_BITS / 2;
   localparam int ANGLE_BITS   = POS_BITS + KPROD_BITS;
   localparam int REM_BITS     = 51;
   localparam int REDUCE_CELLS = ANGLE_BITS;
   localparam int PHASE_BITS   = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS    = 4;
   localparam int CW           = 34;
   localparam int Q15_BITS     = 16;
   localparam int PROD_BITS    = SAMPLE_BITS + Q15_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   // 2*pi in q3.48
   localparam logic [REM_BITS-1:0] TWO_PI_Q48 = 51'h6487ED5110B46;
   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [CW-1:0] Q15_HALF  = 34'sd16384;
   localparam logic signed [CW-1:0] Q15_MAX   = 34'sd32767;
   localparam logic signed [CW-1:0] Q15_MIN   = -34'sd32768;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVENUMBER  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POINT_COUNT = 2'd1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic signed [POS_BITS-1:0]    x;
      logic signed [POS_BITS-1:0]    y;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } point_type;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [SLOT_BITS-1:0] slot;
   } issue_type;

   typedef struct packed {
      logic [KPROD_BITS-1:0] kx;
      logic [KPROD_BITS-1:0] ky;
      logic                  qx_neg;
      logic                  qy_neg;
   } qctx_type;

   typedef struct packed {
      logic                          valid;
      logic                          last;
      logic                          neg;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic [ANGLE_BITS-1:0]         num;
      logic [REM_BITS-1:0]           rem;
      logic [PHASE_BITS-1:0]         ph;
   } mod_lane_type;

   typedef struct packed {
      logic                          valid;
      logic                          last;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic [1:0]                    quad;
      logic signed [CW-1:0]          x;
      logic signed [CW-1:0]          y;
      logic signed [CW-1:0]          z;
   } cordic_lane_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [CW-1:0] atan_turns(input logic [STEP_BITS-1:0] step);
      logic signed [CW-1:0] r;
      case (step)
         4'd0:    r = 34'sd536870912;
         4'd1:    r = 34'sd316933406;
         4'd2:    r = 34'sd167458907;
         4'd3:    r = 34'sd85004756;
         4'd4:    r = 34'sd42667331;
         4'd5:    r = 34'sd21354465;
         4'd6:    r = 34'sd10679838;
         4'd7:    r = 34'sd5340245;
         4'd8:    r = 34'sd2670163;
         4'd9:    r = 34'sd1335087;
         4'd10:   r = 34'sd667544;
         4'd11:   r = 34'sd333772;
         4'd12:   r = 34'sd166886;
         4'd13:   r = 34'sd83443;
         4'd14:   r = 34'sd41722;
         4'd15:   r = 34'sd20861;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/ndft_mod_cell.sv
// one restoring step of the modulo 2*pi reduction and phase division chain
module ndft_mod_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ndft_pkg::mod_lane_type from_prev,
   output ndft_pkg::mod_lane_type to_next
);
   import ndft_pkg::*;

   logic [REM_BITS:0] trial;
   logic              fits;
   mod_lane_type      lane_in;
   mod_lane_type      lane_ff;

   always_comb begin
      trial   = {from_prev.rem, from_prev.num[ANGLE_BITS-1]};
      fits    = (trial >= {1'b0, TWO_PI_Q48});
      lane_in = from_prev;
      lane_in.rem = fits ? REM_BITS'(trial - {1'b0, TWO_PI_Q48}) : trial[REM_BITS-1:0];
      lane_in.num = {from_prev.num[ANGLE_BITS-2:0], 1'b0};
      lane_in.ph  = {from_prev.ph[PHASE_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign to_next = lane_ff;

endmodule

// File: sv/ndft_cordic_cell.sv
// one cordic rotation step
module ndft_cordic_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ndft_pkg::STEP_BITS-1:0] step,
   input  ndft_pkg::cordic_lane_type    from_prev,
   output ndft_pkg::cordic_lane_type    to_next
);
   import ndft_pkg::*;

   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   logic signed [CW-1:0] da;
   cordic_lane_type      lane_in;
   cordic_lane_type      lane_ff;

   always_comb begin
      dx      = $signed(from_prev.y) >>> step;
      dy      = $signed(from_prev.x) >>> step;
      da      = atan_turns(step);
      lane_in = from_prev;
      if (!from_prev.z[CW-1]) begin
         lane_in.x = from_prev.x - dx;
         lane_in.y = from_prev.y + dy;
         lane_in.z = from_prev.z - da;
      end else begin
         lane_in.x = from_prev.x + dx;
         lane_in.y = from_prev.y - dy;
         lane_in.z = from_prev.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign to_next = lane_ff;

endmodule

// File: sv/ndft_angle.sv
// point table and exact angle front end feeding the reduction chain
module ndft_angle (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [ndft_pkg::SLOT_BITS-1:0] wr_slot,
   input  ndft_pkg::point_type           wr_point,
   input  ndft_pkg::issue_type           issue,
   input  ndft_pkg::qctx_type            ctx,
   output ndft_pkg::mod_lane_type        lane_out
);
   import ndft_pkg::*;

   typedef struct packed {
      logic                          last;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } side_type;

   point_type             mem [MAX_POINTS];
   point_type             rd_ff;
   logic                  last0_ff;
   logic [8:0]            vld_ff;
   side_type              side_ff [1:8];
   logic [POS_BITS-1:0]   mx_ff [1:3];
   logic [POS_BITS-1:0]   my_ff [1:5];
   logic                  nx_ff [1:6];
   logic                  ny_ff [1:7];
   logic [KPROD_BITS-1:0] xl_ff;
   logic [KPROD_BITS-1:0] xl3_ff;
   logic [KPROD_BITS-1:0] xh_ff;
   logic [KPROD_BITS-1:0] yl_ff;
   logic [KPROD_BITS-1:0] yl5_ff;
   logic [KPROD_BITS-1:0] yh_ff;
   logic [ANGLE_BITS-1:0] tx_ff;
   logic [ANGLE_BITS-1:0] tx5_ff;
   logic [ANGLE_BITS-1:0] ty_ff;
   logic [ANGLE_BITS-1:0] ax_ff;
   logic [ANGLE_BITS-1:0] ax7_ff;
   logic [ANGLE_BITS-1:0] ay_ff;
   logic [ANGLE_BITS-1:0] a_ff;
   mod_lane_type          lane_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_point;
      end
      if (issue.valid) begin
         rd_ff <= mem[issue.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[7:0], issue.valid};
      end
   end

   always_ff @(posedge clock) begin
      last0_ff <= issue.last;
      // magnitudes and term signs
      mx_ff[1]   <= rd_ff.x[POS_BITS-1] ? POS_BITS'(~rd_ff.x) + POS_BITS'(1) : rd_ff.x;
      my_ff[1]   <= rd_ff.y[POS_BITS-1] ? POS_BITS'(~rd_ff.y) + POS_BITS'(1) : rd_ff.y;
      nx_ff[1]   <= rd_ff.x[POS_BITS-1] ^ ctx.qx_neg;
      ny_ff[1]   <= rd_ff.y[POS_BITS-1] ^ ctx.qy_neg;
      side_ff[1] <= '{last: last0_ff, re: rd_ff.re, im: rd_ff.im};
      for (int k = 2; k <= 8; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      for (int k = 2; k <= 3; k++) begin
         mx_ff[k] <= mx_ff[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
         my_ff[k] <= my_ff[k-1];
      end
      for (int k = 2; k <= 6; k++) begin
         nx_ff[k] <= nx_ff[k-1];
      end
      for (int k = 2; k <= 7; k++) begin
         ny_ff[k] <= ny_ff[k-1];
      end
      // partial products of |p| * |q| * k
      xl_ff  <= mx_ff[1] * ctx.kx[HALF_BITS-1:0];
      xh_ff  <= mx_ff[2] * ctx.kx[KPROD_BITS-1:HALF_BITS];
      xl3_ff <= xl_ff;
      tx_ff  <= {{POS_BITS{1'b0}}, xl3_ff} + {xh_ff, {HALF_BITS{1'b0}}};
      yl_ff  <= my_ff[3] * ctx.ky[HALF_BITS-1:0];
      tx5_ff <= tx_ff;
      yh_ff  <= my_ff[4] * ctx.ky[KPROD_BITS-1:HALF_BITS];
      yl5_ff <= yl_ff;
      ty_ff  <= {{POS_BITS{1'b0}}, yl5_ff} + {yh_ff, {HALF_BITS{1'b0}}};
      // the angle is minus the signed sum of both terms
      ax_ff  <= nx_ff[5] ? tx5_ff : ~tx5_ff + ANGLE_BITS'(1);
      ay_ff  <= ny_ff[6] ? ty_ff : ~ty_ff + ANGLE_BITS'(1);
      ax7_ff <= ax_ff;
      a_ff   <= ax7_ff + ay_ff;
      lane_ff.last <= side_ff[8].last;
      lane_ff.re   <= side_ff[8].re;
      lane_ff.im   <= side_ff[8].im;
      lane_ff.neg  <= a_ff[ANGLE_BITS-1];
      lane_ff.num  <= a_ff[ANGLE_BITS-1] ? ~a_ff + ANGLE_BITS'(1) : a_ff;
      lane_ff.rem  <= '0;
      lane_ff.ph   <= '0;
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= vld_ff[8];
      end
   end

   assign lane_out = lane_ff;

endmodule

// File: sv/nonuniform_dft_complex_to_real_2d.sv
// top level of the direct 2d nonuniform dft, complex samples to real values
//
// Input transactions are taken on start while busy is low. A load (req_kind low)
// writes position and sample into table slot req_slot at that edge and keeps busy
// low. A query (req_kind high) raises busy and walks table entries 0 .. n-1,
// n = min(point_count, 4096), one entry per cycle out of the single table read
// port, through the angle front end, a chain of 96 reduction cells and 32 phase
// cells, and 16 cordic cells, into a multiply-accumulate stage.
// A query with n zero returns a zero result without walking the table. The next
// query can start in the cycle of the result strobe.
// The result is on rsp_value / rsp_final_result for exactly one cycle with
// rsp_valid high; the receiver cannot hold it off and need not.
// Registers are to be written through csr_valid/csr_index/csr_wdata while the
// block is idle (unenforced); csr_ready is always high. Index 0 is wavenumber,
// 1 is point_count. Reset clears both registers and the state; table contents
// are undefined until loaded and no entry may be read before it is written.
module nonuniform_dft_complex_to_real_2d (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic [ndft_pkg::SLOT_BITS-1:0]       req_slot,
   input  logic signed [ndft_pkg::POS_BITS-1:0] req_pos_x,
   input  logic signed [ndft_pkg::POS_BITS-1:0] req_pos_y,
   input  logic signed [ndft_pkg::SAMPLE_BITS-1:0] req_sample_re,
   input  logic signed [ndft_pkg::SAMPLE_BITS-1:0] req_sample_im,
   input  logic                                 req_final_query,
   output logic                                 rsp_valid,
   output logic signed [ndft_pkg::VALUE_BITS-1:0] rsp_value,
   output logic                                 rsp_final_result,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ndft_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ndft_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ndft_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_KX    = 5'b00010,
      ST_KY    = 5'b00100,
      ST_ISSUE = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   function automatic logic signed [Q15_BITS-1:0] to_q15(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      r = (v + Q15_HALF) >>> 15;
      if (r > Q15_MAX) begin
         r = Q15_MAX;
      end else if (r < Q15_MIN) begin
         r = Q15_MIN;
      end
      return r[Q15_BITS-1:0];
   endfunction

   state_type                     state_ff, state_in;
   logic [WAVE_BITS-1:0]          wave_ff;
   logic [COUNT_BITS-1:0]         count_ff;
   logic signed [POS_BITS-1:0]    qx_ff, qy_ff;
   logic                          final_ff;
   logic [KPROD_BITS-1:0]         kx_ff, ky_ff;
   logic [COUNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]         n_ff, n_in;
   logic                          accept, load_go, query_go;
   logic                          zero_done;
   logic [POS_BITS-1:0]           sel_mag;
   logic [KPROD_BITS-1:0]         k_prod;
   issue_type                     issue;
   qctx_type                      ctx;
   point_type                     wr_point;

   mod_lane_type                  red_lane [0:REDUCE_CELLS];
   mod_lane_type                  fix_ff, fix_in;
   mod_lane_type                  ph_lane [0:PHASE_BITS];
   logic [PHASE_BITS-1:0]         ph_sum;
   logic [PHASE_BITS-1:0]         ph_res;
   cordic_lane_type               cprep_ff, cprep_in;
   cordic_lane_type               cor_lane [0:CORDIC_STEPS];

   logic signed [CW-1:0]          cx, cy;
   logic                          post_valid_ff, post_last_ff;
   logic signed [SAMPLE_BITS-1:0] post_re_ff, post_im_ff;
   logic signed [Q15_BITS-1:0]    post_c_ff, post_s_ff;
   logic                          prod_valid_ff, prod_last_ff;
   logic signed [PROD_BITS-1:0]   pc_ff, ps_ff;
   logic signed [VALUE_BITS-1:0]  term;
   logic signed [VALUE_BITS-1:0]  acc_ff;
   logic                          mac_done;
   logic                          rsp_valid_ff;
   logic signed [VALUE_BITS-1:0]  rsp_value_ff;
   logic                          rsp_final_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign load_go   = accept && (req_kind == KIND_LOAD);
   assign query_go  = accept && (req_kind == KIND_QUERY);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff  <= '0;
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WAVENUMBER:  wave_ff  <= csr_wdata[WAVE_BITS-1:0];
            CSR_POINT_COUNT: count_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // one shared multiplier forms |q| * k for both axes
   assign sel_mag = (state_ff == ST_KX)
                    ? (qx_ff[POS_BITS-1] ? POS_BITS'(~qx_ff) + POS_BITS'(1) : qx_ff)
                    : (qy_ff[POS_BITS-1] ? POS_BITS'(~qy_ff) + POS_BITS'(1) : qy_ff);
   assign k_prod  = sel_mag * wave_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      zero_done   = 1'b0;
      issue.valid = 1'b0;
      issue.last  = (cnt_ff == n_ff - COUNT_BITS'(1));
      issue.slot  = cnt_ff[SLOT_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in = ST_KX;
               n_in = (count_ff > COUNT_BITS'(MAX_POINTS)) ? COUNT_BITS'(MAX_POINTS) : count_ff;
            end
         end
         ST_KX: begin
            state_in = ST_KY;
         end
         ST_KY: begin
            cnt_in = '0;
            if (n_ff == '0) begin
               zero_done = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            issue.valid = 1'b1;
            cnt_in      = cnt_ff + COUNT_BITS'(1);
            if (issue.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      if (query_go) begin
         qx_ff    <= req_pos_x;
         qy_ff    <= req_pos_y;
         final_ff <= req_final_query;
      end
      if (state_ff == ST_KX) begin
         kx_ff <= k_prod;
      end
      if (state_ff == ST_KY) begin
         ky_ff <= k_prod;
      end
   end

   assign ctx.kx     = kx_ff;
   assign ctx.ky     = ky_ff;
   assign ctx.qx_neg = qx_ff[POS_BITS-1];
   assign ctx.qy_neg = qy_ff[POS_BITS-1];

   assign wr_point.x  = req_pos_x;
   assign wr_point.y  = req_pos_y;
   assign wr_point.re = req_sample_re;
   assign wr_point.im = req_sample_im;

   ndft_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_go),
      .wr_slot  (req_slot),
      .wr_point (wr_point),
      .issue    (issue),
      .ctx      (ctx),
      .lane_out (red_lane[0])
   );

   for (genvar g = 0; g < REDUCE_CELLS; g++) begin : g_reduce
      ndft_mod_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .from_prev (red_lane[g]),
         .to_next   (red_lane[g+1])
      );
   end

   // floored remainder of a negative angle
   always_comb begin
      fix_in = red_lane[REDUCE_CELLS];
      if (red_lane[REDUCE_CELLS].neg && (red_lane[REDUCE_CELLS].rem != '0)) begin
         fix_in.rem = TWO_PI_Q48 - red_lane[REDUCE_CELLS].rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff <= '0;
      end else begin
         fix_ff <= fix_in;
      end
   end

   assign ph_lane[0] = fix_ff;

   for (genvar g = 0; g < PHASE_BITS; g++) begin : g_phase
      ndft_mod_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .from_prev (ph_lane[g]),
         .to_next   (ph_lane[g+1])
      );
   end

   // quadrant split, residual in [-2^29, 2^29)
   always_comb begin
      ph_sum         = ph_lane[PHASE_BITS].ph + 32'h2000_0000;
      cprep_in.valid = ph_lane[PHASE_BITS].valid;
      cprep_in.last  = ph_lane[PHASE_BITS].last;
      cprep_in.re    = ph_lane[PHASE_BITS].re;
      cprep_in.im    = ph_lane[PHASE_BITS].im;
      cprep_in.quad  = ph_sum[PHASE_BITS-1:PHASE_BITS-2];
      ph_res         = ph_lane[PHASE_BITS].ph - {ph_sum[PHASE_BITS-1:PHASE_BITS-2], 30'b0};
      cprep_in.x     = CORDIC_X0;
      cprep_in.y     = '0;
      cprep_in.z     = CW'($signed(ph_res));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cprep_ff <= '0;
      end else begin
         cprep_ff <= cprep_in;
      end
   end

   assign cor_lane[0] = cprep_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      ndft_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (STEP_BITS'(g)),
         .from_prev (cor_lane[g]),
         .to_next   (cor_lane[g+1])
      );
   end

   always_comb begin
      case (cor_lane[CORDIC_STEPS].quad)
         2'd0: begin
            cx = cor_lane[CORDIC_STEPS].x;
            cy = cor_lane[CORDIC_STEPS].y;
         end
         2'd1: begin
            cx = -cor_lane[CORDIC_STEPS].y;
            cy = cor_lane[CORDIC_STEPS].x;
         end
         2'd2: begin
            cx = -cor_lane[CORDIC_STEPS].x;
            cy = -cor_lane[CORDIC_STEPS].y;
         end
         default: begin
            cx = cor_lane[CORDIC_STEPS].y;
            cy = -cor_lane[CORDIC_STEPS].x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         post_valid_ff <= cor_lane[CORDIC_STEPS].valid;
         prod_valid_ff <= post_valid_ff;
      end
      post_last_ff <= cor_lane[CORDIC_STEPS].last;
      post_re_ff   <= cor_lane[CORDIC_STEPS].re;
      post_im_ff   <= cor_lane[CORDIC_STEPS].im;
      post_c_ff    <= to_q15(cx);
      post_s_ff    <= to_q15(cy);
      prod_last_ff <= post_last_ff;
      pc_ff        <= post_re_ff * post_c_ff;
      ps_ff        <= post_im_ff * post_s_ff;
   end

   assign term     = VALUE_BITS'(pc_ff) - VALUE_BITS'(ps_ff);
   assign mac_done = prod_valid_ff && prod_last_ff;

   always_ff @(posedge clock) begin
      if (query_go) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + term;
      end
      rsp_value_ff <= zero_done ? '0 : acc_ff + term;
      rsp_final_ff <= final_ff;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mac_done || zero_done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_final_result = rsp_final_ff;

endmodule

// File: sv/ndft_checker.sv
// port-level checker for the nonuniform dft block and its bind
`include "nonuniform_dft_complex_to_real_2d_assert.svh"

module ndft_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_kind,
   input logic rsp_valid
);

   `NDFT_ASSERT(a_single_strobe, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `NDFT_ASSERT(a_idle_on_result, rsp_valid |-> !busy, "busy still high in the result cycle")
   `NDFT_ASSERT(a_query_goes_busy, (start && !busy && req_kind) |=> busy, "query did not raise busy")
   `NDFT_ASSERT(a_busy_from_query, $rose(busy) |-> $past(start && req_kind), "busy rose without a query")
   `NDFT_ASSERT_RST(a_reset_quiet, $past(reset) |-> (!busy && !rsp_valid), "activity after reset")

endmodule

bind nonuniform_dft_complex_to_real_2d ndft_checker u_ndft_checker (.*);

// File: bench/tb_nonuniform_dft_complex_to_real_2d.sv
// testbench of the 2d nonuniform dft block: table loads, queries and register writes
`timescale 1ns / 1ps

class dft_scoreboard;
   localparam logic signed [127:0] TWO_PI = 128'sh6487ED5110B46;
   localparam longint ATAN [16] = '{536870912, 316933406, 167458907, 85004756,
      42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

   logic [31:0]        wave;
   logic [12:0]        count;
   logic signed [31:0] tab_x [4096];
   logic signed [31:0] tab_y [4096];
   logic signed [15:0] tab_re [4096];
   logic signed [15:0] tab_im [4096];
   logic [48:0]        pending [$];   // {final, value}
   int                 fails;

   function void write_reg(logic [1:0] idx, logic [31:0] data);
      if (idx == ndft_pkg::CSR_WAVENUMBER) wave = data;
      else if (idx == ndft_pkg::CSR_POINT_COUNT) count = data[12:0];
   endfunction

   function logic [31:0] phase_turns(logic signed [31:0] px, logic signed [31:0] py,
                                     logic signed [31:0] qx, logic signed [31:0] qy);
      logic signed [127:0] k, ang, r, sx, sy, tx, ty, f;
      k = {96'b0, wave};
      sx = px; sy = py; tx = qx; ty = qy;
      ang = -(sx * tx * k + sy * ty * k);
      r = ang % TWO_PI;
      if (r < 0) r = r + TWO_PI;
      f = (r <<< 32) / TWO_PI;
      return f[31:0];
   endfunction

   function longint to_q15(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function void rotate(logic [31:0] ph, output longint c, output longint s);
      logic [1:0]  q;
      logic [31:0] d, sum;
      longint x, y, z, dx, dy;
      sum = ph + 32'h20000000;
      q = sum[31:30];
      d = ph - {q, 30'b0};
      z = longint'(signed'(d));
      x = 652032874; y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN[i];
         end else begin
            x += dx; y -= dy; z += ATAN[i];
         end
      end
      case (q)
         2'd0: begin c = to_q15(x); s = to_q15(y); end
         2'd1: begin c = to_q15(-y); s = to_q15(x); end
         2'd2: begin c = to_q15(-x); s = to_q15(-y); end
         default: begin c = to_q15(y); s = to_q15(-x); end
      endcase
   endfunction

   function void note_item(logic kind, logic [11:0] slot, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [15:0] re,
                           logic signed [15:0] im, logic fin);
      longint acc, c, s;
      int n;
      if (kind == ndft_pkg::KIND_LOAD) begin
         tab_x[slot] = px; tab_y[slot] = py; tab_re[slot] = re; tab_im[slot] = im;
         return;
      end
      n = (count > 4096) ? 4096 : count;
      acc = 0;
      for (int i = 0; i < n; i++) begin
         rotate(phase_turns(tab_x[i], tab_y[i], px, py), c, s);
         acc += longint'(tab_re[i]) * c - longint'(tab_im[i]) * s;
      end
      pending.push_back({fin, acc[47:0]});
   endfunction

   function void check_result(logic [47:0] value, logic fin);
      logic [48:0] e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result value %h final %b", $time, value, fin);
         fails++;
         return;
      end
      e = pending.pop_front();
      if (e[47:0] !== value) begin
         $display("%0t: value expected %h actual %h", $time, e[47:0], value);
         fails++;
      end
      if (e[48] !== fin) begin
         $display("%0t: final expected %b actual %b", $time, e[48], fin);
         fails++;
      end
   endfunction
endclass

module tb_nonuniform_dft_complex_to_real_2d;
   import ndft_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   logic clock, reset, start, busy, rsp_valid, rsp_final_result;
   logic req_kind, req_final_query, csr_valid, csr_ready;
   logic [SLOT_BITS-1:0] req_slot;
   logic signed [POS_BITS-1:0] req_pos_x, req_pos_y;
   logic signed [SAMPLE_BITS-1:0] req_sample_re, req_sample_im;
   logic signed [VALUE_BITS-1:0] rsp_value;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int idle_pct;
   dft_scoreboard sb;

   nonuniform_dft_complex_to_real_2d u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_valid) sb.check_result(rsp_value, rsp_final_result);

   // start stays high between back-to-back transactions
   task automatic send(logic kind, logic [11:0] slot, logic signed [31:0] px,
                       logic signed [31:0] py, logic signed [15:0] re,
                       logic signed [15:0] im, logic fin);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind; req_slot <= slot; req_pos_x <= px; req_pos_y <= py;
      req_sample_re <= re; req_sample_im <= im; req_final_query <= fin;
      do @(posedge clock); while (busy);
      sb.note_item(kind, slot, px, py, re, im, fin);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
         1: return $urandom() % 2 ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [31:0] wv;
      sb = new();
      idle_pct = 0;
      reset = 1; start = 0; csr_valid = 0; csr_index = '0; csr_wdata = '0;
      req_kind = KIND_LOAD; req_slot = '0; req_pos_x = '0; req_pos_y = '0;
      req_sample_re = '0; req_sample_im = '0; req_final_query = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero count gives zero
      write_csr(CSR_WAVENUMBER, 32'h00010000);
      write_csr(CSR_POINT_COUNT, 13'd0);
      send(KIND_QUERY, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1'b1);
      // extremes of samples and positions; final flag on a load is ignored
      send(KIND_LOAD, 0, 32'h7FFFFFFF, 32'h80000000, 16'sh7FFF, -16'sh8000, 1'b1);
      send(KIND_LOAD, 1, 32'h80000000, 32'h7FFFFFFF, -16'sh8000, 16'sh7FFF, 1'b0);
      send(KIND_LOAD, 2, 0, 0, -16'sh8000, -16'sh8000, 1'b0);
      send(KIND_LOAD, 3, 32'hFFFFFFFF, 32'h00010000, 16'sh7FFF, 16'sh7FFF, 1'b0);
      for (int i = 4; i < 16; i++)
         send(KIND_LOAD, i, rand_pos(), rand_pos(), $urandom(), $urandom(), 1'b0);
      drain();
      write_csr(CSR_POINT_COUNT, 13'd16);
      send(KIND_QUERY, 0, 0, 0, 0, 0, 1'b0);
      send(KIND_QUERY, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1'b1);
      send(KIND_QUERY, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 1'b0);
      drain();
      write_csr(CSR_SPARE, 32'hFFFFFFFF);
      write_csr(CSR_WAVENUMBER, 32'hFFFFFFFF);
      send(KIND_QUERY, 0, 32'h80000000, 32'h80000000, 0, 0, 1'b1);
      drain();

      // random phases, each with its own settings
      for (int p = 0; p < 6; p++) begin
         idle_pct = (p < 2) ? 21 : (p < 4) ? 45 : 0;
         case (p % 4)
            0: wv = 32'h0;
            1: wv = 32'hFFFFFFFF;
            2: wv = $urandom_range(0, 32'h40000);
            default: wv = $urandom();
         endcase
         write_csr(CSR_WAVENUMBER, wv);
         write_csr(CSR_POINT_COUNT, (p == 3) ? 13'd0 : $urandom_range(1, 16));
         if (p == 5) write_csr(CSR_SPARE_HI, $urandom());
         for (int i = 0; i < 20; i++) begin
            if ($urandom_range(99) < 45)
               send(KIND_QUERY, $urandom(), rand_pos(), rand_pos(), $urandom(),
                    $urandom(), $urandom());
            else
               send(KIND_LOAD, ($urandom() % 2) ? $urandom_range(0, 15) : $urandom(),
                    rand_pos(), rand_pos(), $urandom(), $urandom(), $urandom());
         end
         drain();
      end
      repeat (200) @(posedge clock);

      if (sb.fails == 0 && sb.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// File: sim.f
+incdir+sv
sv/ndft_pkg.sv
sv/ndft_mod_cell.sv
sv/ndft_cordic_cell.sv
sv/ndft_angle.sv
sv/nonuniform_dft_complex_to_real_2d.sv
sv/ndft_checker.sv
bench/tb_nonuniform_dft_complex_to_real_2d.sv
